// ===== design/kclc_pkg.sv =====
// ----------------------------------------------------------------------------
// kclc_pkg
// Shared types, codes and helpers for the keypad code lock controller.
// ----------------------------------------------------------------------------
package kclc_pkg;

  localparam int unsigned CodeDigits = 6;
  localparam int unsigned CodeW      = 4 * CodeDigits;
  localparam int unsigned AdminW     = 24;
  localparam int unsigned FailW      = 4;

  localparam logic [AdminW-1:0] AdminCodeRst   = 24'h522008;
  localparam logic [FailW-1:0]  MaxFailuresRst = 4'd3;
  localparam logic [CodeW-1:0]  UserCodeRst    = CodeW'(24'h123456);
  localparam logic [FailW-1:0]  FailSat        = 4'd15;

  localparam logic CfgAdminCode   = 1'b0;
  localparam logic CfgMaxFailures = 1'b1;

  localparam logic [3:0] KeyAdmin      = 4'd10;
  localparam logic [3:0] KeyLeaveAdmin = 4'd11;
  localparam logic [3:0] KeyExit       = 4'd12;
  localparam logic [3:0] KeyClearAlarm = 4'd13;
  localparam logic [3:0] KeyLock       = 4'd14;
  localparam logic [3:0] KeyEnter      = 4'd15;

  typedef enum logic [1:0] {
    OpDigit  = 2'd0,
    OpFunc   = 2'd1,
    OpRemote = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ModeNormal = 3'd0,
    ModeAdmin  = 3'd1,
    ModeNew1   = 3'd2,
    ModeNew2   = 3'd3,
    ModeAlarm  = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    StNone       = 4'd0,
    StCodeOk     = 4'd1,
    StCodeWrong  = 4'd2,
    StAdminOk    = 4'd3,
    StAdminWrong = 4'd4,
    StCodeSet    = 4'd5,
    StMismatch   = 4'd6,
    StLocked     = 4'd7,
    StExit       = 4'd8,
    StAlarmClr   = 4'd9,
    StRemoteOpen = 4'd10
  } status_e;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] key;
  } item_t;

  typedef struct packed {
    logic       door_open;
    logic       alarm_on;
    logic [2:0] mode;
    logic [3:0] status;
  } result_t;

  function automatic logic [CodeW-1:0] shift_digit(input logic [CodeW-1:0] code_v,
                                                   input logic [3:0] digit);
    return {code_v[CodeW-5:0], digit};
  endfunction

endpackage

// ===== design/kclc_in_stage.sv =====
// ----------------------------------------------------------------------------
// kclc_in_stage
// Input register: holds one keypad event until the core takes it.
// ----------------------------------------------------------------------------
module kclc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     op_i,
  input  logic [3:0]     key_i,
  input  logic           advance_i,
  output logic           item_valid_o,
  output kclc_pkg::item_t item_o
);
  import kclc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{op: op_i, key: key_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== design/kclc_core.sv =====
// ----------------------------------------------------------------------------
// kclc_core
// Lock state and next-state logic: code buffers, failure count, mode, door.
// ----------------------------------------------------------------------------
module kclc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  kclc_pkg::item_t               item_i,
  input  logic [kclc_pkg::AdminW-1:0]   admin_code_i,
  input  logic [kclc_pkg::FailW-1:0]    max_failures_i,
  output kclc_pkg::result_t             res_d_o
);
  import kclc_pkg::*;

  logic [CodeW-1:0] entry_q, entry_d;
  logic [CodeW-1:0] user_q, user_d;
  logic [CodeW-1:0] first_q, first_d;
  logic [CodeW-1:0] second_q, second_d;
  logic [FailW-1:0] fail_q, fail_d;
  mode_e            mode_q, mode_d;
  logic             door_q, door_d;
  status_e          status;

  logic [FailW-1:0] fail_inc;
  logic [FailW-1:0] fail_enter;
  logic             user_match;
  logic             admin_match;

  assign fail_inc    = (fail_q != FailSat) ? fail_q + 4'd1 : fail_q;
  assign user_match  = (entry_q == user_q);
  assign admin_match = (entry_q == CodeW'(admin_code_i));
  assign fail_enter  = user_match ? '0 : fail_inc;

  always_comb begin
    entry_d  = entry_q;
    user_d   = user_q;
    first_d  = first_q;
    second_d = second_q;
    fail_d   = fail_q;
    mode_d   = mode_q;
    door_d   = door_q;
    status   = StNone;
    case (item_i.op)
      OpRemote: begin
        door_d = 1'b1;
        status = StRemoteOpen;
      end
      OpDigit: begin
        case (mode_q)
          ModeNormal, ModeAdmin: entry_d = shift_digit(entry_q, item_i.key);
          ModeNew1:              first_d = shift_digit(first_q, item_i.key);
          ModeNew2:              second_d = shift_digit(second_q, item_i.key);
          default: ;
        endcase
      end
      OpFunc: begin
        case (mode_q)
          ModeNormal: begin
            if (item_i.key == KeyEnter) begin
              fail_d = fail_enter;
              if (user_match) begin
                door_d  = 1'b1;
                entry_d = '0;
                status  = StCodeOk;
              end else begin
                status = StCodeWrong;
              end
              if (fail_enter >= max_failures_i) begin
                mode_d = ModeAlarm;
              end
            end else if (item_i.key == KeyLock) begin
              door_d  = 1'b0;
              entry_d = '0;
              status  = StLocked;
            end else if (item_i.key == KeyAdmin) begin
              mode_d = ModeAdmin;
            end else if (item_i.key == KeyExit) begin
              status = StExit;
            end
          end
          ModeAdmin: begin
            if (item_i.key == KeyEnter) begin
              if (admin_match) begin
                entry_d = '0;
                mode_d  = ModeNew1;
                status  = StAdminOk;
              end else begin
                mode_d = ModeNormal;
                status = StAdminWrong;
              end
            end else if (item_i.key == KeyLeaveAdmin) begin
              mode_d = ModeNormal;
              status = StExit;
            end
          end
          ModeNew1: begin
            if (item_i.key == KeyEnter) begin
              mode_d = ModeNew2;
            end else if (item_i.key == KeyLeaveAdmin) begin
              mode_d = ModeNormal;
              status = StExit;
            end
          end
          ModeNew2: begin
            if (item_i.key == KeyEnter) begin
              if (first_q == second_q) begin
                user_d = first_q;
                fail_d = '0;
                status = StCodeSet;
              end else begin
                status = StMismatch;
              end
              mode_d = ModeNormal;
            end
          end
          default: begin
            if (item_i.key == KeyClearAlarm) begin
              fail_d = '0;
              mode_d = ModeNormal;
              status = StAlarmClr;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q  <= '0;
      user_q   <= UserCodeRst[CodeW-1:0];
      first_q  <= '0;
      second_q <= '0;
      fail_q   <= '0;
      mode_q   <= ModeNormal;
      door_q   <= 1'b0;
    end else if (fire_i) begin
      entry_q  <= entry_d;
      user_q   <= user_d;
      first_q  <= first_d;
      second_q <= second_d;
      fail_q   <= fail_d;
      mode_q   <= mode_d;
      door_q   <= door_d;
    end
  end

  assign res_d_o = '{door_open: door_d,
                     alarm_on:  (mode_d == ModeAlarm),
                     mode:      mode_d,
                     status:    status};

endmodule

// ===== design/kclc_out_stage.sv =====
// ----------------------------------------------------------------------------
// kclc_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module kclc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  kclc_pkg::result_t res_d_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kclc_pkg::result_t res_o
);
  import kclc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_d_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/keypad_code_lock_controller_unit.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_unit
// Keypad code lock: user code entry, failure alarm and admin code change.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    op_i, key_i
// result    out        out_valid_o / out_stall_i  door_open_o, alarm_on_o,
//                                                 mode_o, status_o
// config    in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Each event passes the input register, then the state update and the result
// register, from which its result is offered once the state update fires.
// One event is taken every cycle while the result side keeps up.
// Reset restores the default admin code, failure limit, user code and mode.
// A stalled result holds the input register; the input stalls only while both
// registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [kclc_pkg::AdminW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic [3:0]                  key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        door_open_o,
  output logic                        alarm_on_o,
  output logic [2:0]                  mode_o,
  output logic [3:0]                  status_o
);
  import kclc_pkg::*;

  logic [AdminW-1:0] admin_code_q;
  logic [FailW-1:0]  max_failures_q;
  logic              advance;
  logic              item_valid;
  logic              fire;
  item_t             item;
  result_t           res_d;
  result_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      admin_code_q   <= AdminCodeRst;
      max_failures_q <= MaxFailuresRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAdminCode:   admin_code_q <= cfg_wdata_i;
        CfgMaxFailures: max_failures_q <= cfg_wdata_i[FailW-1:0];
        default: ;
      endcase
    end
  end

  assign fire = item_valid && advance;

  kclc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .key_i        (key_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  kclc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (item),
    .admin_code_i   (admin_code_q),
    .max_failures_i (max_failures_q),
    .res_d_o        (res_d)
  );

  kclc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_d_i     (res_d),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign door_open_o = res.door_open;
  assign alarm_on_o  = res.alarm_on;
  assign mode_o      = res.mode;
  assign status_o    = res.status;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register can drain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alarm_on_o == (mode_o == ModeAlarm)))
    else $error("alarm flag disagrees with the mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StCodeOk || status_o == StRemoteOpen)) |-> door_open_o)
    else $error("door closed after an open event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StAlarmClr) |-> (mode_o == ModeNormal))
    else $error("alarm clear did not return to normal mode");

endmodule

// ===== tb/kclc_lock_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kclc_lock_checker
// Watches the event and result channels of the keypad code lock controller.
// Every accepted event is run through a local model of the lock to get the
// result it should produce. Every accepted result is compared field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module kclc_lock_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [kclc_pkg::AdminW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  op_i,
  input  logic [3:0]                  key_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        door_open_i,
  input  logic                        alarm_on_i,
  input  logic [2:0]                  mode_i,
  input  logic [3:0]                  status_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);
  import kclc_pkg::*;

  logic [AdminW-1:0] admin_code_q;
  logic [FailW-1:0]  fail_limit_q;
  logic [CodeW-1:0]  entry_q;
  logic [CodeW-1:0]  user_code_q;
  logic [CodeW-1:0]  new_first_q;
  logic [CodeW-1:0]  new_second_q;
  logic [FailW-1:0]  fail_count_q;
  mode_e             mode_q;
  logic              door_q;
  result_t           lock_results_q[$];

  function automatic result_t advance_lock(input logic [1:0] op, input logic [3:0] key);
    status_e st;
    result_t res;
    st = StNone;
    case (op)
      OpRemote: begin
        door_q = 1'b1;
        st = StRemoteOpen;
      end
      OpDigit: begin
        case (mode_q)
          ModeNormal, ModeAdmin: entry_q = {entry_q[CodeW-5:0], key};
          ModeNew1:              new_first_q = {new_first_q[CodeW-5:0], key};
          ModeNew2:              new_second_q = {new_second_q[CodeW-5:0], key};
          default: ;
        endcase
      end
      OpFunc: begin
        case (mode_q)
          ModeNormal: begin
            if (key == KeyEnter) begin
              if (fail_count_q != FailSat) fail_count_q = fail_count_q + 1'b1;
              if (entry_q == user_code_q) begin
                door_q = 1'b1;
                entry_q = '0;
                fail_count_q = '0;
                st = StCodeOk;
              end else begin
                st = StCodeWrong;
              end
              if (fail_count_q >= fail_limit_q) mode_q = ModeAlarm;
            end else if (key == KeyLock) begin
              door_q = 1'b0;
              entry_q = '0;
              st = StLocked;
            end else if (key == KeyAdmin) begin
              mode_q = ModeAdmin;
            end else if (key == KeyExit) begin
              st = StExit;
            end
          end
          ModeAdmin: begin
            if (key == KeyEnter) begin
              if (entry_q == CodeW'(admin_code_q)) begin
                entry_q = '0;
                mode_q = ModeNew1;
                st = StAdminOk;
              end else begin
                mode_q = ModeNormal;
                st = StAdminWrong;
              end
            end else if (key == KeyLeaveAdmin) begin
              mode_q = ModeNormal;
              st = StExit;
            end
          end
          ModeNew1: begin
            if (key == KeyEnter) begin
              mode_q = ModeNew2;
            end else if (key == KeyLeaveAdmin) begin
              mode_q = ModeNormal;
              st = StExit;
            end
          end
          ModeNew2: begin
            if (key == KeyEnter) begin
              if (new_first_q == new_second_q) begin
                user_code_q = new_first_q;
                fail_count_q = '0;
                st = StCodeSet;
              end else begin
                st = StMismatch;
              end
              mode_q = ModeNormal;
            end
          end
          default: begin
            if (key == KeyClearAlarm) begin
              fail_count_q = '0;
              mode_q = ModeNormal;
              st = StAlarmClr;
            end
          end
        endcase
      end
      default: ;
    endcase
    res.door_open = door_q;
    res.alarm_on  = (mode_q == ModeAlarm);
    res.mode      = mode_q;
    res.status    = st;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      admin_code_q     = AdminCodeRst;
      fail_limit_q     = MaxFailuresRst;
      entry_q          = '0;
      user_code_q      = UserCodeRst[CodeW-1:0];
      new_first_q      = '0;
      new_second_q     = '0;
      fail_count_q     = '0;
      mode_q           = ModeNormal;
      door_q           = 1'b0;
      lock_results_q.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
      checked_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (lock_results_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result with nothing outstanding: %s%0b %s%0b %s%0d %s%0d",
                     $time, "door=", door_open_i, "alarm=", alarm_on_i,
                     "mode=", mode_i, "status=", status_i);
        end else begin
          want = lock_results_q.pop_front();
          checked_o++;
          if (door_open_i !== want.door_open || alarm_on_i !== want.alarm_on ||
              mode_i !== want.mode || status_i !== want.status) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: mismatch: expected door=%0b alarm=%0b mode=%0d status=%0d,",
                       $time, want.door_open, want.alarm_on, want.mode, want.status);
              $display("  got door=%0b alarm=%0b mode=%0d status=%0d",
                       door_open_i, alarm_on_i, mode_i, status_i);
            end
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgAdminCode) admin_code_q = cfg_wdata_i;
        else fail_limit_q = cfg_wdata_i[FailW-1:0];
      end
      if (in_valid_i && !in_stall_i) lock_results_q.push_back(advance_lock(op_i, key_i));
      pending_o = lock_results_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keypad code lock controller.
// A short directed sequence walks through every mode and key, then random
// phases under several register settings mix correct code entries, code
// changes, alarm bursts and noise, with random idling on both channels in all but one phase.
// ----------------------------------------------------------------------------
module tb_top;
  import kclc_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CfgAdminCode;
  logic [AdminW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        op_i = OpDigit;
  logic [3:0]        key_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              door_open_o;
  logic              alarm_on_o;
  logic [2:0]        mode_o;
  logic [3:0]        status_o;

  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       checked;
  int unsigned       sent_events = 0;
  int unsigned       settings = 1;
  bit                idle_tx = 1'b1;
  bit                idle_rx = 1'b1;
  logic              hold_trig = 1'b0;
  logic              hold_seen = 1'b0;
  int unsigned       hold_left = 0;
  logic [AdminW-1:0] admin_now = AdminCodeRst;
  logic [CodeW-1:0]  user_guess = UserCodeRst[CodeW-1:0];

  keypad_code_lock_controller_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .door_open_o (door_open_o),
    .alarm_on_o  (alarm_on_o),
    .mode_o      (mode_o),
    .status_o    (status_o)
  );

  kclc_lock_checker lock_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .key_i            (key_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .door_open_i      (door_open_o),
    .alarm_on_i       (alarm_on_o),
    .mode_i           (mode_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 60;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_rx && ($urandom_range(99) < 8);
    end
  end

  task automatic send_event(input logic [1:0] op, input logic [3:0] key);
    in_valid_i <= 1'b1;
    op_i <= op;
    key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    sent_events++;
    if (idle_tx && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic press_key(input logic [3:0] key);
    send_event(OpFunc, key);
  endtask

  task automatic enter_digits(input logic [CodeW-1:0] code);
    for (int i = CodeDigits - 1; i >= 0; i--) send_event(OpDigit, code[4*i +: 4]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [AdminW-1:0] admin, input logic [FailW-1:0] limit);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgAdminCode;
    cfg_wdata_i <= admin;
    @(posedge clk_i);
    cfg_idx_i <= CfgMaxFailures;
    cfg_wdata_i <= AdminW'(limit);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    admin_now = admin;
  endtask

  task automatic random_sequence();
    int unsigned      pick;
    int unsigned      idx;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] fresh;
    bit               admin_ok;
    bit               same;
    pick = $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(99) < 60) begin
        press_key(KeyClearAlarm);
        press_key(KeyLeaveAdmin);
      end
      code = user_guess;
      if ($urandom_range(99) < 25) begin
        idx = $urandom_range(CodeDigits - 1);
        code[4*idx +: 4] = code[4*idx +: 4] ^ 4'($urandom_range(1, 15));
      end
      enter_digits(code);
      press_key(KeyEnter);
      if ($urandom_range(99) < 40) press_key(KeyLock);
    end else if (pick < 55) begin
      press_key(KeyClearAlarm);
      press_key(KeyLeaveAdmin);
      press_key(KeyAdmin);
      admin_ok = ($urandom_range(99) < 85);
      code = admin_now[CodeW-1:0];
      if (!admin_ok) code = code ^ (CodeW'(1) << $urandom_range(CodeW - 1));
      enter_digits(code);
      press_key(KeyEnter);
      if (admin_ok && $urandom_range(99) < 10) begin
        press_key(KeyLeaveAdmin);
      end else begin
        fresh = CodeW'($urandom);
        same = ($urandom_range(99) < 75);
        enter_digits(fresh);
        press_key(KeyEnter);
        code = same ? fresh : fresh ^ (CodeW'(1) << $urandom_range(CodeW - 1));
        enter_digits(code);
        if ($urandom_range(99) < 15) press_key(KeyLeaveAdmin);
        press_key(KeyEnter);
        if (admin_ok && same) user_guess = fresh;
      end
    end else if (pick < 70) begin
      press_key(KeyClearAlarm);
      press_key(KeyLeaveAdmin);
      repeat ($urandom_range(1, 16)) begin
        send_event(OpDigit, 4'($urandom_range(15)));
        press_key(KeyEnter);
      end
      repeat ($urandom_range(0, 3)) send_event(2'($urandom_range(3)), 4'($urandom_range(15)));
      if ($urandom_range(99) < 85) press_key(KeyClearAlarm);
    end else if (pick < 80) begin
      case ($urandom_range(6))
        0: send_event(OpRemote, 4'($urandom_range(15)));
        1: press_key(KeyLock);
        2: press_key(KeyExit);
        3: press_key(KeyLeaveAdmin);
        4: press_key(KeyClearAlarm);
        5: press_key(KeyAdmin);
        default: send_event(OpUnused, 4'($urandom_range(15)));
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) send_event(2'($urandom_range(3)), 4'($urandom_range(15)));
    end
  endtask

  task automatic run_phase(input logic [AdminW-1:0] admin, input logic [FailW-1:0] limit,
                           input int unsigned count, input bit idle_on, input bit squeeze);
    int unsigned stop_at;
    settle();
    set_config(admin, limit);
    settings++;
    idle_tx = idle_on;
    idle_rx = idle_on;
    if (squeeze) hold_trig <= ~hold_trig;
    stop_at = sent_events + count;
    while (sent_events < stop_at) random_sequence();
  endtask

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(OpUnused, KeyEnter);
    enter_digits(UserCodeRst[CodeW-1:0]);
    press_key(KeyEnter);
    press_key(KeyLock);
    press_key(KeyExit);
    press_key(KeyLeaveAdmin);
    press_key(KeyClearAlarm);
    send_event(OpRemote, 4'd0);
    send_event(OpDigit, 4'd15);
    send_event(OpDigit, 4'd0);
    repeat (3) press_key(KeyEnter);
    send_event(OpDigit, 4'd9);
    press_key(KeyEnter);
    press_key(KeyAdmin);
    send_event(OpRemote, 4'd15);
    press_key(KeyClearAlarm);

    settle();
    set_config('0, 4'd1);
    press_key(KeyLock);
    press_key(KeyAdmin);
    press_key(KeyEnter);
    send_event(OpDigit, 4'd7);
    press_key(KeyEnter);
    press_key(KeyLeaveAdmin);
    send_event(OpDigit, 4'd7);
    press_key(KeyEnter);
    user_guess = CodeW'(7);
    press_key(KeyAdmin);
    press_key(KeyLeaveAdmin);
    press_key(KeyAdmin);
    send_event(OpDigit, 4'd3);
    press_key(KeyEnter);
    press_key(KeyEnter);
    press_key(KeyClearAlarm);

    run_phase(AdminW'($urandom), 4'($urandom_range(1, 15)), 300, 1'b1, 1'b0);
    run_phase({AdminW{1'b1}}, 4'd15, 300, 1'b1, 1'b1);
    run_phase('0, 4'd1, 300, 1'b0, 1'b0);
    run_phase(AdminW'($urandom), 4'd0, 300, 1'b1, 1'b0);
    run_phase(AdminW'($urandom), 4'($urandom_range(15)), 300, 1'b1, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d keypad events and %0d checked results under %0d register settings,",
             sent_events, checked, settings);
    $display("with a long result hold, a phase without idling and every mode of the lock.");
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
